// ===== rtl/core/tbgl_pkg.sv =====
// Shared types, constants and the color table of the temperature bar graph block.
package tbgl_pkg;

    // Field widths
    localparam int TEMP_W   = 16;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int PIXEL_W  = 24;
    localparam int PIXELS   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Fractional quotient bits of the bar position (8 pixels x 256 steps)
    localparam int POS_W     = 11;
    localparam int DIV_STEPS = POS_W;
    localparam int STEP_CNT_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_BASE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BT_END       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_PERIOD = 3'd3;

    // Register reset values
    localparam logic signed [TEMP_W-1:0] BAR_BASE_RST   = 16'sd320;
    localparam logic signed [TEMP_W-1:0] BT_END_RST     = 16'sd3440;
    localparam logic signed [TEMP_W-1:0] ENV_LIMIT_RST  = 16'sd6400;
    localparam logic [PERIOD_W-1:0]      PULSE_PERIOD_RST = 16'd500;

    typedef logic [PIXEL_W-1:0] pixel_t;

    localparam pixel_t COLOR_OFF  = 24'h000000;
    localparam pixel_t COLOR_WARN = 24'hFF0000;

    // Green-to-red bar gradient, pixel 0 first
    localparam pixel_t GRADIENT [PIXELS] = '{
        24'h00FF00, 24'h6EFF00, 24'hDCFF00, 24'hFFD800,
        24'hFFA100, 24'hFF6A00, 24'hFF3500, 24'hFF0000
    };

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // take the input transaction
        logic load;     // evaluate warning, span and clamp
        logic step;     // one restoring division step
        logic write;    // fill the output register
    } tbgl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic skip;      // no division needed for this item
        logic out_free;  // output register can take a result
    } tbgl_status_t;

endpackage

// ===== rtl/core/tbgl_ctrl.sv =====
// Controller state machine: sequences capture, setup, serial division and output write.
module tbgl_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tbgl_pkg::tbgl_status_t status,
    output tbgl_pkg::tbgl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    localparam logic [tbgl_pkg::STEP_CNT_W-1:0] LAST_STEP =
        tbgl_pkg::STEP_CNT_W'(tbgl_pkg::DIV_STEPS - 1);

    state_t state_reg, state_next;
    logic [tbgl_pkg::STEP_CNT_W-1:0] cnt_reg, cnt_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (status.skip) begin
                    state_next = ST_WRITE;
                end else begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP) begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                if (status.out_free) begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/tbgl_dp.sv =====
// Datapath: config registers, pulse state, bar divider and registered pixel output.
module tbgl_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_we,
    input  logic [tbgl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tbgl_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input payload
    input  logic signed [tbgl_pkg::TEMP_W-1:0]    env_temp,
    input  logic signed [tbgl_pkg::TEMP_W-1:0]    bean_temp,
    input  logic [tbgl_pkg::TIME_W-1:0]           now_ms,
    // control
    input  tbgl_pkg::tbgl_cmd_t                   cmd,
    output tbgl_pkg::tbgl_status_t                status,
    // result
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output tbgl_pkg::pixel_t [tbgl_pkg::PIXELS-1:0] pixels,
    output logic                                  warning
);

    localparam int TW = tbgl_pkg::TEMP_W;

    // Configuration registers
    logic signed [TW-1:0] bar_base_reg, bt_end_reg, env_limit_reg;
    logic [tbgl_pkg::PERIOD_W-1:0] pulse_period_reg;

    // Pulse state
    logic [tbgl_pkg::TIME_W-1:0] last_toggle_reg;
    logic                        pulse_on_reg;

    // Captured transaction
    logic signed [TW-1:0]        et_reg, bt_reg;
    logic [tbgl_pkg::TIME_W-1:0] now_reg;

    // Setup results and divider
    logic              warn_reg, empty_reg, full_reg, skip_reg;
    logic [TW-1:0]     span_reg, rem_reg;
    logic [tbgl_pkg::POS_W-1:0] quo_reg;

    // Output register
    logic            m_valid_reg;
    tbgl_pkg::pixel_t [tbgl_pkg::PIXELS-1:0] pixels_reg, pixels_next;
    logic            warning_reg;

    // Setup logic
    logic signed [TW:0] span_w, num_w, num_clamp;
    logic               empty_w, full_w, warn_w, toggle_w;
    logic [tbgl_pkg::TIME_W-1:0] elapsed_w;

    always_comb begin
        span_w  = {bt_end_reg[TW-1], bt_end_reg} - {bar_base_reg[TW-1], bar_base_reg};
        num_w   = {bt_reg[TW-1], bt_reg} - {bar_base_reg[TW-1], bar_base_reg};
        empty_w = span_w[TW] || (span_w == '0);
        priority if (num_w[TW]) begin
            num_clamp = '0;
        end else if (num_w > span_w) begin
            num_clamp = span_w;
        end else begin
            num_clamp = num_w;
        end
        full_w    = (num_clamp == span_w);
        warn_w    = (et_reg >= env_limit_reg);
        elapsed_w = now_reg - last_toggle_reg;
        toggle_w  = (elapsed_w >= {{(tbgl_pkg::TIME_W - tbgl_pkg::PERIOD_W){1'b0}},
                                   pulse_period_reg});
    end

    // Restoring division step
    logic [TW:0] shifted_w, diff_w;
    logic        ge_w;

    always_comb begin
        shifted_w = {rem_reg, 1'b0};
        diff_w    = shifted_w - {1'b0, span_reg};
        ge_w      = (shifted_w >= {1'b0, span_reg});
    end

    // Write config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_base_reg     <= tbgl_pkg::BAR_BASE_RST;
            bt_end_reg       <= tbgl_pkg::BT_END_RST;
            env_limit_reg    <= tbgl_pkg::ENV_LIMIT_RST;
            pulse_period_reg <= tbgl_pkg::PULSE_PERIOD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tbgl_pkg::CFG_BAR_BASE:     bar_base_reg     <= cfg_data;
                tbgl_pkg::CFG_BT_END:       bt_end_reg       <= cfg_data;
                tbgl_pkg::CFG_ENV_LIMIT:    env_limit_reg    <= cfg_data;
                tbgl_pkg::CFG_PULSE_PERIOD: pulse_period_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Toggle the warning pulse on setup in warning mode once the pulse period has elapsed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_toggle_reg <= '0;
            pulse_on_reg    <= 1'b0;
        end else if (cmd.load && warn_w && toggle_w) begin
            last_toggle_reg <= now_reg;
            pulse_on_reg    <= ~pulse_on_reg;
        end
    end

    // Capture, setup and divide
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= 1'b0;
        end else if (cmd.load) begin
            skip_reg <= warn_w || empty_w || full_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            et_reg  <= env_temp;
            bt_reg  <= bean_temp;
            now_reg <= now_ms;
        end
        if (cmd.load) begin
            warn_reg  <= warn_w;
            empty_reg <= empty_w;
            full_reg  <= full_w;
            span_reg  <= span_w[TW-1:0];
            rem_reg   <= num_clamp[TW-1:0];
            quo_reg   <= '0;
        end else if (cmd.step) begin
            rem_reg <= ge_w ? diff_w[TW-1:0] : shifted_w[TW-1:0];
            quo_reg <= {quo_reg[tbgl_pkg::POS_W-2:0], ge_w};
        end
    end

    // Build the pixel row
    logic [3:0]        lit_w;
    logic [7:0]        frac_w;
    tbgl_pkg::pixel_t  sel_w, dim_w;
    logic [15:0]       prod_r, prod_g, prod_b;

    always_comb begin
        lit_w  = full_reg ? 4'd8 : {1'b0, quo_reg[tbgl_pkg::POS_W-1:8]};
        frac_w = quo_reg[7:0];
        sel_w  = tbgl_pkg::GRADIENT[quo_reg[tbgl_pkg::POS_W-1:8]];
        prod_r = sel_w[23:16] * frac_w;
        prod_g = sel_w[15:8] * frac_w;
        prod_b = sel_w[7:0] * frac_w;
        dim_w  = {prod_r[15:8], prod_g[15:8], prod_b[15:8]};
        for (int i = 0; i < tbgl_pkg::PIXELS; i++) begin
            priority if (warn_reg) begin
                pixels_next[i] = pulse_on_reg ? tbgl_pkg::COLOR_WARN : tbgl_pkg::COLOR_OFF;
            end else if (empty_reg) begin
                pixels_next[i] = tbgl_pkg::COLOR_OFF;
            end else if (4'(i) < lit_w) begin
                pixels_next[i] = tbgl_pkg::GRADIENT[i];
            end else if (4'(i) == lit_w) begin
                pixels_next[i] = dim_w;
            end else begin
                pixels_next[i] = tbgl_pkg::COLOR_OFF;
            end
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.write) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            pixels_reg  <= pixels_next;
            warning_reg <= warn_reg;
        end
    end

    assign status.skip     = skip_reg;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign pixels          = pixels_reg;
    assign warning         = warning_reg;

endmodule

// ===== rtl/core/temperature_bar_graph_leds_top.sv =====
// Top level of the temperature bar graph: eight RGB pixels from two temperatures and a time.
//
// Usage:
//   Input channel (s_valid/s_ready): one transaction carries env_temp, bean_temp and
//   now_ms. Result channel (m_valid/m_ready): one transaction per input with eight
//   24-bit pixels and the warning flag. Config channel (cfg_valid/cfg_ready) writes
//   the bar base, bar end, warning threshold and pulse period by index; it is always
//   ready and indexes 4 to 7 are ignored. Write config only while the block is idle.
// Sequencing:
//   Warning mode, an empty span or a full bar skip the divider. Otherwise the bar
//   position comes from a restoring divider that resolves one quotient bit per
//   cycle. In either case a new input transaction is taken only after the last
//   one has been written to the output register.
// Reset (aresetn, synchronous, active low) restores the register defaults, turns
//   the pulse off with its time mark at zero, and empties the output register.
// Stall: the output register holds a result until m_ready; the next item is taken
//   and worked meanwhile, and waits before its own write until the register frees.
module temperature_bar_graph_leds_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tbgl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbgl_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tbgl_pkg::TEMP_W-1:0]  s_env_temp,
    input  logic signed [tbgl_pkg::TEMP_W-1:0]  s_bean_temp,
    input  logic [tbgl_pkg::TIME_W-1:0]         s_now_ms,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tbgl_pkg::PIXEL_W-1:0]        m_pixel0,
    output logic [tbgl_pkg::PIXEL_W-1:0]        m_pixel1,
    output logic [tbgl_pkg::PIXEL_W-1:0]        m_pixel2,
    output logic [tbgl_pkg::PIXEL_W-1:0]        m_pixel3,
    output logic [tbgl_pkg::PIXEL_W-1:0]        m_pixel4,
    output logic [tbgl_pkg::PIXEL_W-1:0]        m_pixel5,
    output logic [tbgl_pkg::PIXEL_W-1:0]        m_pixel6,
    output logic [tbgl_pkg::PIXEL_W-1:0]        m_pixel7,
    output logic                                m_warning
);

    tbgl_pkg::tbgl_cmd_t    cmd;
    tbgl_pkg::tbgl_status_t status;
    tbgl_pkg::pixel_t [tbgl_pkg::PIXELS-1:0] pixels;

    assign cfg_ready = 1'b1;

    // Sequence each transaction
    tbgl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Compute and hold the pixel row
    tbgl_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .env_temp  (s_env_temp),
        .bean_temp (s_bean_temp),
        .now_ms    (s_now_ms),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .pixels    (pixels),
        .warning   (m_warning)
    );

    assign m_pixel0 = pixels[0];
    assign m_pixel1 = pixels[1];
    assign m_pixel2 = pixels[2];
    assign m_pixel3 = pixels[3];
    assign m_pixel4 = pixels[4];
    assign m_pixel5 = pixels[5];
    assign m_pixel6 = pixels[6];
    assign m_pixel7 = pixels[7];

endmodule

// ===== rtl/core/tbgl_checker.sv =====
// Port-level checker for the temperature bar graph top level, with its bind.
module tbgl_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [tbgl_pkg::PIXEL_W-1:0]    m_pixel0,
    input logic [tbgl_pkg::PIXEL_W-1:0]    m_pixel1,
    input logic [tbgl_pkg::PIXEL_W-1:0]    m_pixel2,
    input logic [tbgl_pkg::PIXEL_W-1:0]    m_pixel3,
    input logic [tbgl_pkg::PIXEL_W-1:0]    m_pixel4,
    input logic [tbgl_pkg::PIXEL_W-1:0]    m_pixel5,
    input logic [tbgl_pkg::PIXEL_W-1:0]    m_pixel6,
    input logic [tbgl_pkg::PIXEL_W-1:0]    m_pixel7,
    input logic                            m_warning
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A pending result stays until taken
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // Warning shows one uniform pulse color
    a_warn_uniform: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_warning |->
            m_pixel1 == m_pixel0 && m_pixel2 == m_pixel0 && m_pixel3 == m_pixel0 &&
            m_pixel4 == m_pixel0 && m_pixel5 == m_pixel0 && m_pixel6 == m_pixel0 &&
            m_pixel7 == m_pixel0 &&
            (m_pixel0 == tbgl_pkg::COLOR_WARN || m_pixel0 == tbgl_pkg::COLOR_OFF))
        else $error("warning pixels not uniform");

    // The bar fills from the first pixel
    a_bar_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_warning && m_pixel1 != tbgl_pkg::COLOR_OFF |->
            m_pixel0 == tbgl_pkg::GRADIENT[0])
        else $error("bar pixel lit above an unlit one");

endmodule

bind temperature_bar_graph_leds_top tbgl_checker u_tbgl_checker (.*);

// ===== sim/temperature_bar_graph_leds_top_test.sv =====
// Self-checking testbench for the temperature bar graph top level.
`timescale 1ns / 100ps

module temperature_bar_graph_leds_top_test;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no transaction before giving up
    localparam int LONG_HOLD    = 400;   // receiver hold-off for the backpressure test
    localparam int DRAIN_CYCLES = 32;    // idle cycles run after the last strip before the summary
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 100;

    // Indexes with no register behind them
    localparam logic [tbgl_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
    localparam logic [tbgl_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef logic signed [tbgl_pkg::TEMP_W-1:0] temp_t;

    typedef struct packed {
        tbgl_pkg::pixel_t [tbgl_pkg::PIXELS-1:0] pix;
        logic                                    warn;
    } strip_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tbgl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tbgl_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    temp_t                           s_env_temp = '0;
    temp_t                           s_bean_temp = '0;
    logic [tbgl_pkg::TIME_W-1:0]     s_now_ms = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    tbgl_pkg::pixel_t                m_pixel0, m_pixel1, m_pixel2, m_pixel3;
    tbgl_pkg::pixel_t                m_pixel4, m_pixel5, m_pixel6, m_pixel7;
    logic                            m_warning;

    // Shadow of the block's registers and pulse state
    int                          bar_lo;
    int                          bar_hi;
    int                          warn_level;
    int                          blink_ms;
    logic [tbgl_pkg::TIME_W-1:0] toggle_mark;
    logic                        blink_lit;

    strip_t                      strips_pending[$];
    int                          strips_due = 0;
    logic [tbgl_pkg::TIME_W-1:0] wall_ms = '0;

    bit feed_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    bit hold_off_req = 1'b0;

    int mismatches = 0;
    int readings_sent = 0;
    int strips_checked = 0;
    int warn_strips = 0;
    int reg_writes = 0;

    temperature_bar_graph_leds_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_env_temp  (s_env_temp),
        .s_bean_temp (s_bean_temp),
        .s_now_ms    (s_now_ms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel0    (m_pixel0),
        .m_pixel1    (m_pixel1),
        .m_pixel2    (m_pixel2),
        .m_pixel3    (m_pixel3),
        .m_pixel4    (m_pixel4),
        .m_pixel5    (m_pixel5),
        .m_pixel6    (m_pixel6),
        .m_pixel7    (m_pixel7),
        .m_warning   (m_warning)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic temp_t clamp16(input int v);
        if (v > 32767) begin
            return temp_t'(32767);
        end
        if (v < -32768) begin
            return temp_t'(-32768);
        end
        return v[tbgl_pkg::TEMP_W-1:0];
    endfunction

    // Compute the strip the block must show for one reading; advance the pulse state
    function automatic strip_t render_strip(input temp_t et, input temp_t bt,
                                            input logic [tbgl_pkg::TIME_W-1:0] now);
        strip_t                      s;
        logic [tbgl_pkg::TIME_W-1:0] elapsed;
        int                          span;
        int                          num;
        longint                      pos;
        int                          lit;
        int                          frac;
        s = '0;
        if (int'(et) >= warn_level) begin
            elapsed = now - toggle_mark;
            if (elapsed >= tbgl_pkg::TIME_W'(blink_ms)) begin
                toggle_mark = now;
                blink_lit = ~blink_lit;
            end
            for (int i = 0; i < tbgl_pkg::PIXELS; i++) begin
                s.pix[i] = blink_lit ? tbgl_pkg::COLOR_WARN : tbgl_pkg::COLOR_OFF;
            end
            s.warn = 1'b1;
            return s;
        end
        span = bar_hi - bar_lo;
        if (span <= 0) begin
            return s;
        end
        num = int'(bt) - bar_lo;
        if (num < 0) begin
            num = 0;
        end
        if (num > span) begin
            num = span;
        end
        pos  = (longint'(num) * 2048) / longint'(span);
        lit  = int'(pos >> 8);
        frac = int'(pos & 255);
        for (int i = 0; i < tbgl_pkg::PIXELS; i++) begin
            if (i < lit) begin
                s.pix[i] = tbgl_pkg::GRADIENT[i];
            end else if (i == lit) begin
                for (int c = 0; c < 3; c++) begin
                    s.pix[i][c*8 +: 8] = (tbgl_pkg::GRADIENT[i][c*8 +: 8] * frac) >> 8;
                end
            end
        end
        return s;
    endfunction

    // Offer one reading and queue its expected strip once accepted
    task automatic send_reading(input temp_t et, input temp_t bt,
                                input logic [tbgl_pkg::TIME_W-1:0] now);
        if (feed_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_env_temp  <= et;
        s_bean_temp <= bt;
        s_now_ms    <= now;
        do @(posedge aclk); while (!s_ready);
        strips_pending.push_back(render_strip(et, bt, now));
        strips_due++;
        readings_sent++;
    endtask

    // Drop valid and wait until every strip has come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        wait (strips_due == 0);
        @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [tbgl_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[tbgl_pkg::CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tbgl_pkg::CFG_BAR_BASE:
                bar_lo = int'($signed(value[tbgl_pkg::CFG_DATA_W-1:0]));
            tbgl_pkg::CFG_BT_END:
                bar_hi = int'($signed(value[tbgl_pkg::CFG_DATA_W-1:0]));
            tbgl_pkg::CFG_ENV_LIMIT:
                warn_level = int'($signed(value[tbgl_pkg::CFG_DATA_W-1:0]));
            tbgl_pkg::CFG_PULSE_PERIOD:
                blink_ms = int'(value[tbgl_pkg::CFG_DATA_W-1:0]);
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    // Compare one accepted strip with the oldest expectation
    task automatic check_strip();
        strip_t           want;
        tbgl_pkg::pixel_t seen [tbgl_pkg::PIXELS];
        seen = '{m_pixel0, m_pixel1, m_pixel2, m_pixel3,
                 m_pixel4, m_pixel5, m_pixel6, m_pixel7};
        if (strips_pending.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected strip, warning %0b pixel0 %06h",
                     $time, m_warning, m_pixel0);
            return;
        end
        want = strips_pending.pop_front();
        strips_due--;
        strips_checked++;
        if (want.warn) begin
            warn_strips++;
        end
        for (int i = 0; i < tbgl_pkg::PIXELS; i++) begin
            if (seen[i] !== want.pix[i]) begin
                mismatches++;
                $display("%0t: pixel%0d expected %06h actual %06h",
                         $time, i, want.pix[i], seen[i]);
            end
        end
        if (m_warning !== want.warn) begin
            mismatches++;
            $display("%0t: warning expected %0b actual %0b",
                     $time, want.warn, m_warning);
        end
    endtask

    // Accept strips with random stall bursts, or one long hold-off on request
    initial begin : strip_sink
        int hold;
        hold = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                check_strip();
            end
            if (hold_off_req) begin
                hold = LONG_HOLD;
                hold_off_req = 1'b0;
            end else if (hold == 0 && sink_stalls && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 16);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("temperature_bar_graph_leds_top_test: FAIL");
        $finish;
    end

    // Pick a random register setting, extremes and spare indexes included
    task automatic random_setup();
        int kind;
        int lo;
        int hi;
        logic [tbgl_pkg::CFG_IDX_W-1:0] spare;
        kind = $urandom_range(0, 9);
        wait_idle();
        if (kind == 0) begin
            lo = rand_between(-4096, 20000);
            hi = lo - rand_between(0, 500);
        end else if (kind == 1) begin
            lo = rand_between(-32768, 32767);
            hi = rand_between(-32768, 32767);
        end else if (kind == 2) begin
            lo = -32768;
            hi = 32767;
        end else begin
            lo = rand_between(-4096, 8000);
            hi = lo + rand_between(1, 6000);
        end
        cfg_write(tbgl_pkg::CFG_BAR_BASE, lo);
        cfg_write(tbgl_pkg::CFG_BT_END, hi);
        if ($urandom_range(0, 7) == 0) begin
            cfg_write(tbgl_pkg::CFG_ENV_LIMIT, rand_between(-32768, 32767));
        end else begin
            cfg_write(tbgl_pkg::CFG_ENV_LIMIT, rand_between(-4096, 32767));
        end
        case ($urandom_range(0, 9))
            0:       cfg_write(tbgl_pkg::CFG_PULSE_PERIOD, 0);
            1:       cfg_write(tbgl_pkg::CFG_PULSE_PERIOD, 65535);
            default: cfg_write(tbgl_pkg::CFG_PULSE_PERIOD, rand_between(1, 1500));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            spare = tbgl_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI));
            cfg_write(spare, int'($urandom));
        end
        // Park the clock just before its wrap now and then
        if ($urandom_range(0, 3) == 0) begin
            wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        end
    endtask

    // One reading, mostly near the thresholds, sometimes anywhere in the field
    task automatic random_reading();
        temp_t et;
        temp_t bt;
        int    span;
        int    pick;
        span = bar_hi - bar_lo;
        if (span < 0) begin
            span = -span;
        end
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            et = temp_t'($urandom_range(0, 65535));
        end else if (pick < 6) begin
            et = clamp16(warn_level + rand_between(0, 200));
        end else begin
            et = clamp16(warn_level - rand_between(1, 3000));
        end
        if ($urandom_range(0, 9) < 2) begin
            bt = temp_t'($urandom_range(0, 65535));
        end else begin
            bt = clamp16(bar_lo + rand_between(-150, span + 150));
        end
        if ($urandom_range(0, 29) == 0) begin
            wall_ms = $urandom;
        end else begin
            wall_ms += rand_between(0, 2 * blink_ms + 2);
        end
        send_reading(et, bt, wall_ms);
    endtask

    // Bar shape under the reset setting: empty, clamped, full and partial
    task automatic test_default_bar();
        send_reading(16'sd0, 16'sd320, 32'd0);
        send_reading(16'sd0, -16'sd32768, 32'd10);
        send_reading(16'sd0, 16'sd3440, 32'd20);
        send_reading(16'sd0, 16'sd32767, 32'd30);
        send_reading(16'sd0, 16'sd1880, 32'd40);
        send_reading(16'sd0, 16'sd2000, 32'd50);
        send_reading(-16'sd32768, 16'sd330, 32'd60);
        send_reading(16'sd6399, 16'sd700, 32'd70);
    endtask

    // Pulse toggling, leaving warning mode, and elapsed time across the wrap
    task automatic test_warning_pulse();
        send_reading(16'sd6400, 16'sd0, 32'd500);
        send_reading(16'sd32767, 16'sd0, 32'd999);
        send_reading(16'sd100, 16'sd1000, 32'd1200);
        send_reading(16'sd6400, 16'sd0, 32'd1000);
        send_reading(16'sd7000, 16'sd0, 32'hFFFF_FF00);
        send_reading(16'sd7000, 16'sd0, 32'h0000_0010);
        send_reading(16'sd7000, 16'sd0, 32'h0000_0200);
    endtask

    // Register extremes: zero period, widest span, empty span, spare index
    task automatic test_register_extremes();
        wait_idle();
        cfg_write(tbgl_pkg::CFG_PULSE_PERIOD, 0);
        cfg_write(tbgl_pkg::CFG_ENV_LIMIT, -32768);
        send_reading(-16'sd32768, 16'sd0, 32'hFFFF_FFFF);
        send_reading(-16'sd32768, 16'sd0, 32'hFFFF_FFFF);
        wait_idle();
        cfg_write(tbgl_pkg::CFG_BAR_BASE, -32768);
        cfg_write(tbgl_pkg::CFG_BT_END, 32767);
        cfg_write(tbgl_pkg::CFG_ENV_LIMIT, 32767);
        cfg_write(tbgl_pkg::CFG_PULSE_PERIOD, 65535);
        send_reading(16'sd0, -16'sd32768, 32'd0);
        send_reading(16'sd0, 16'sd32767, 32'd1);
        send_reading(16'sd0, 16'sd0, 32'd2);
        send_reading(-16'sd1, -16'sd1, 32'h5555_AAAA);
        send_reading(16'sd32767, 16'sd0, 32'h0001_2345);
        wait_idle();
        cfg_write(tbgl_pkg::CFG_BAR_BASE, 1000);
        cfg_write(tbgl_pkg::CFG_BT_END, 1000);
        send_reading(16'sd0, 16'sd1000, 32'd10);
        wait_idle();
        cfg_write(tbgl_pkg::CFG_BT_END, 999);
        send_reading(16'sd0, 16'sd5000, 32'd20);
        wait_idle();
        cfg_write(tbgl_pkg::CFG_BT_END, 3000);
        cfg_write(CFG_SPARE_HI, 16'hFFFF);
        send_reading(16'sd0, 16'sd2000, 32'd30);
    endtask

    // Random settings, with stretches where either the sender or the receiver never idles
    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++) begin
            random_setup();
            feed_gaps   = (p % 4) != 3;
            sink_stalls = (p % 4) != 2;
            repeat (PHASE_ITEMS) random_reading();
        end
        feed_gaps   = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // Hold off the receiver while readings keep coming so the input stalls
    task automatic test_backpressure();
        random_setup();
        feed_gaps = 1'b0;
        hold_off_req = 1'b1;
        repeat (24) random_reading();
        feed_gaps = 1'b1;
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_full_rate();
        random_setup();
        feed_gaps   = 1'b0;
        sink_stalls = 1'b0;
        repeat (PHASE_ITEMS) random_reading();
    endtask

    initial begin : run
        bar_lo      = int'(tbgl_pkg::BAR_BASE_RST);
        bar_hi      = int'(tbgl_pkg::BT_END_RST);
        warn_level  = int'(tbgl_pkg::ENV_LIMIT_RST);
        blink_ms    = int'(tbgl_pkg::PULSE_PERIOD_RST);
        toggle_mark = '0;
        blink_lit   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_bar();
        test_warning_pulse();
        test_register_extremes();
        test_random_phases();
        test_backpressure();
        test_full_rate();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d readings and %0d strips (%0d in warning mode)",
                 readings_sent, strips_checked, warn_strips);
        $display("over %0d register writes; %0d mismatches", reg_writes, mismatches);
        if (mismatches == 0 && strips_pending.size() == 0) begin
            $display("temperature_bar_graph_leds_top_test: PASS");
        end else begin
            $display("temperature_bar_graph_leds_top_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tbgl_pkg.sv
rtl/core/tbgl_ctrl.sv
rtl/core/tbgl_dp.sv
rtl/core/temperature_bar_graph_leds_top.sv
rtl/core/tbgl_checker.sv
sim/temperature_bar_graph_leds_top_test.sv
